// ===== hdl/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

  // Default sizes
  localparam int ROM_DEPTH_DEF     = 64;
  localparam int PATTERN_COUNT_DEF = 5;

  // Item kinds
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Remote command bytes
  localparam logic [7:0] CMD_LAMP_ONE = 8'h45;
  localparam logic [7:0] CMD_LAMP_TWO = 8'h44;
  localparam logic [7:0] CMD_BLUE_UP  = 8'h46;
  localparam logic [7:0] CMD_BLUE_DN  = 8'h40;
  localparam logic [7:0] CMD_RED_UP   = 8'h15;
  localparam logic [7:0] CMD_RED_DN   = 8'h19;
  localparam logic [7:0] CMD_GREEN_UP = 8'h18;
  localparam logic [7:0] CMD_GREEN_DN = 8'h1C;
  localparam logic [7:0] CMD_PLAY     = 8'h47;
  localparam logic [7:0] CMD_NEXT     = 8'h43;
  localparam logic [7:0] CMD_PREV     = 8'h09;

  localparam logic [7:0] LEVEL_STEP = 8'd10;

  // Lamp action: bit 1 set means apply, bit 0 is the new state
  localparam int LAMP_APPLY_BIT = 1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  command_code;
    logic [11:0] speed_permille;
  } item_t;

  typedef struct packed {
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic        lamp_one;
    logic        lamp_two;
    logic [10:0] tone_hz;
    logic        tone_active;
    logic        playing;
    logic [2:0]  pattern_number;
    logic [4:0]  step_number;
    logic        unknown_command;
  } result_t;

  // One step of a pattern
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        tone_set;
    logic [10:0] tone_hz;
    logic [1:0]  lamp_one_act;
    logic [1:0]  lamp_two_act;
    logic [8:0]  dur_ms;
  } step_t;

  function automatic step_t mk(input int r, input int g, input int b, input int t,
                               input int hz, input int a1, input int a2, input int d);
    step_t s;
    s.red          = 8'(r);
    s.green        = 8'(g);
    s.blue         = 8'(b);
    s.tone_set     = 1'(t);
    s.tone_hz      = 11'(hz);
    s.lamp_one_act = 2'(a1);
    s.lamp_two_act = 2'(a2);
    s.dur_ms       = 9'(d);
    return s;
  endfunction

  // Pattern step table; entries past the end read as black with no actions
  function automatic step_t step_rom(input logic [7:0] idx);
    step_t s;
    s = '0;
    case (idx)
      // colour circle
      8'd0:  s = mk(255,   0,   0, 1, 0, 0, 0, 80);
      8'd1:  s = mk(255,  64,   0, 1, 0, 0, 0, 80);
      8'd2:  s = mk(255, 128,   0, 1, 0, 0, 0, 80);
      8'd3:  s = mk(255, 192,   0, 1, 0, 0, 0, 80);
      8'd4:  s = mk(255, 255,   0, 1, 0, 0, 0, 80);
      8'd5:  s = mk(192, 255,   0, 1, 0, 0, 0, 80);
      8'd6:  s = mk(128, 255,   0, 1, 0, 0, 0, 80);
      8'd7:  s = mk( 64, 255,   0, 1, 0, 0, 0, 80);
      8'd8:  s = mk(  0, 255,   0, 1, 0, 0, 0, 80);
      8'd9:  s = mk(  0, 255,  64, 1, 0, 0, 0, 80);
      8'd10: s = mk(  0, 255, 128, 1, 0, 0, 0, 80);
      8'd11: s = mk(  0, 255, 192, 1, 0, 0, 0, 80);
      8'd12: s = mk(  0, 255, 255, 1, 0, 0, 0, 80);
      8'd13: s = mk(  0, 192, 255, 1, 0, 0, 0, 80);
      8'd14: s = mk(  0, 128, 255, 1, 0, 0, 0, 80);
      8'd15: s = mk(  0,  64, 255, 1, 0, 0, 0, 80);
      8'd16: s = mk(  0,   0, 255, 1, 0, 0, 0, 80);
      8'd17: s = mk( 64,   0, 255, 1, 0, 0, 0, 80);
      8'd18: s = mk(128,   0, 255, 1, 0, 0, 0, 80);
      8'd19: s = mk(192,   0, 255, 1, 0, 0, 0, 80);
      8'd20: s = mk(255,   0, 255, 1, 0, 0, 0, 80);
      8'd21: s = mk(255,   0, 192, 1, 0, 0, 0, 80);
      8'd22: s = mk(255,   0, 128, 1, 0, 0, 0, 80);
      8'd23: s = mk(255,   0,  64, 1, 0, 0, 0, 80);
      8'd24: s = mk(255,   0,   0, 1, 0, 0, 0, 80);
      // police
      8'd25: s = mk(255,   0,   0, 1,  800, 3, 0, 200);
      8'd26: s = mk(  0,   0,   0, 0,    0, 0, 0, 100);
      8'd27: s = mk(255,   0,   0, 1,  800, 3, 0, 200);
      8'd28: s = mk(  0,   0,   0, 1,    0, 0, 0, 300);
      8'd29: s = mk(  0,   0, 255, 1,  600, 0, 3, 200);
      8'd30: s = mk(  0,   0,   0, 0,    0, 0, 0, 100);
      8'd31: s = mk(  0,   0, 255, 1,  600, 0, 3, 200);
      8'd32: s = mk(  0,   0,   0, 1,    0, 0, 0, 300);
      // fire
      8'd33: s = mk(255,  80,   0, 0, 0, 0, 0, 120);
      8'd34: s = mk(255, 120,  10, 0, 0, 0, 0, 100);
      8'd35: s = mk(255,  60,   0, 0, 0, 0, 0, 150);
      8'd36: s = mk(255, 100,  20, 0, 0, 0, 0,  80);
      8'd37: s = mk(255,  40,   0, 0, 0, 0, 0, 200);
      8'd38: s = mk(255, 150,  30, 0, 0, 0, 0,  90);
      8'd39: s = mk(255,  70,   5, 0, 0, 0, 0, 110);
      8'd40: s = mk(255, 110,  15, 0, 0, 0, 0, 130);
      // ocean
      8'd41: s = mk(  0,  50, 100, 0, 0, 0, 0, 300);
      8'd42: s = mk(  0,  80, 150, 0, 0, 0, 0, 250);
      8'd43: s = mk(  0, 120, 200, 0, 0, 0, 0, 200);
      8'd44: s = mk(  0, 150, 255, 0, 0, 0, 0, 150);
      8'd45: s = mk( 20, 180, 255, 0, 0, 0, 0, 100);
      8'd46: s = mk(  0, 150, 255, 0, 0, 0, 0, 150);
      8'd47: s = mk(  0, 120, 200, 0, 0, 0, 0, 200);
      8'd48: s = mk(  0,  80, 150, 0, 0, 0, 0, 250);
      8'd49: s = mk(  0,  50, 100, 0, 0, 0, 0, 300);
      // disco
      8'd50: s = mk(255,   0,   0, 1, 1000, 3, 2, 80);
      8'd51: s = mk(  0,   0,   0, 0,    0, 0, 0, 40);
      8'd52: s = mk(  0, 255,   0, 1, 1200, 2, 3, 80);
      8'd53: s = mk(  0,   0,   0, 0,    0, 0, 0, 40);
      8'd54: s = mk(  0,   0, 255, 1, 1400, 3, 2, 80);
      8'd55: s = mk(  0,   0,   0, 0,    0, 0, 0, 40);
      8'd56: s = mk(255, 255,   0, 1, 1600, 2, 3, 80);
      8'd57: s = mk(  0,   0,   0, 0,    0, 0, 0, 40);
      8'd58: s = mk(255,   0, 255, 1, 1800, 3, 3, 80);
      8'd59: s = mk(  0,   0,   0, 0,    0, 0, 0, 40);
      8'd60: s = mk(  0, 255, 255, 1, 2000, 2, 2, 80);
      8'd61: s = mk(  0,   0,   0, 0,    0, 0, 0, 40);
      default: s = '0;
    endcase
    return s;
  endfunction

  // First table entry of each pattern
  function automatic logic [7:0] pat_start(input logic [2:0] p);
    logic [7:0] v;
    case (p)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd25;
      3'd2:    v = 8'd33;
      3'd3:    v = 8'd41;
      3'd4:    v = 8'd50;
      default: v = 8'd62;
    endcase
    return v;
  endfunction

  // Step count of each pattern; unused slots are empty
  function automatic logic [4:0] pat_len(input logic [2:0] p);
    logic [4:0] v;
    case (p)
      3'd0:    v = 5'd25;
      3'd1:    v = 5'd8;
      3'd2:    v = 5'd8;
      3'd3:    v = 5'd9;
      3'd4:    v = 5'd12;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sat_up(input logic [7:0] v);
    return (v > (8'd255 - LEVEL_STEP)) ? 8'd255 : v + LEVEL_STEP;
  endfunction

  function automatic logic [7:0] sat_dn(input logic [7:0] v);
    return (v < LEVEL_STEP) ? 8'd0 : v - LEVEL_STEP;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lps_ram.sv =====
`default_nettype none

module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lps_loader.sv =====
`default_nettype none

// Copies the step table into the pattern RAM after reset, one entry a cycle.
module lps_loader #(
  parameter int DEPTH = lps_pkg::ROM_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  output logic                          we,
  output logic [$clog2(DEPTH)-1:0]      waddr,
  output logic [$bits(lps_pkg::step_t)-1:0] wdata,
  output logic                          done
);

  localparam int AW = $clog2(DEPTH);

  logic [AW:0] cnt;

  assign done  = (cnt == (AW+1)'(DEPTH));
  assign we    = !done;
  assign waddr = cnt[AW-1:0];
  assign wdata = lps_pkg::step_rom(8'(cnt[AW-1:0]));

  // Sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (!done) begin
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lps_core.sv =====
`default_nettype none

// Sequencer state and its update for one transaction.
module lps_core #(
  parameter int PATTERN_COUNT = lps_pkg::PATTERN_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            commit,
  input  wire lps_pkg::item_t  item,
  input  wire lps_pkg::step_t  entry,
  output lps_pkg::result_t     res_next,
  output logic [2:0]           pattern_look,
  output logic [4:0]           step_look
);

  localparam logic [2:0] PAT_LAST = 3'(PATTERN_COUNT - 1);

  logic [7:0]  red, green, blue;
  logic        lamp_one, lamp_two, play, tone_on;
  logic [2:0]  pattern;
  logic [4:0]  step;
  logic [18:0] accum;
  logic [10:0] tone;

  logic [7:0]  red_next, green_next, blue_next;
  logic        lamp_one_next, lamp_two_next, play_next, tone_on_next;
  logic [2:0]  pattern_next;
  logic [4:0]  step_next;
  logic [18:0] accum_next;
  logic [10:0] tone_next;
  logic        unknown;

  logic [4:0]  len;
  logic [4:0]  step_eff;
  logic [4:0]  step_inc;
  logic [18:0] sum;
  logic [18:0] dur_full;

  // Next state for the transaction in flight
  always_comb begin
    red_next      = red;
    green_next    = green;
    blue_next     = blue;
    lamp_one_next = lamp_one;
    lamp_two_next = lamp_two;
    play_next     = play;
    tone_on_next  = tone_on;
    pattern_next  = pattern;
    step_next     = step;
    accum_next    = accum;
    tone_next     = tone;
    unknown       = 1'b0;

    len      = lps_pkg::pat_len(pattern);
    step_eff = (step >= len) ? 5'd0 : step;
    step_inc = (step_eff + 5'd1 >= len) ? 5'd0 : step_eff + 5'd1;
    sum      = accum + 19'(item.speed_permille);
    dur_full = 19'(entry.dur_ms) * 19'd1000;

    if (commit) begin
      if (item.operation == lps_pkg::OP_COMMAND) begin
        case (item.command_code)
          lps_pkg::CMD_LAMP_ONE: lamp_one_next = !lamp_one;
          lps_pkg::CMD_LAMP_TWO: lamp_two_next = !lamp_two;
          lps_pkg::CMD_BLUE_UP: begin
            play_next = 1'b0;
            blue_next = lps_pkg::sat_up(blue);
          end
          lps_pkg::CMD_BLUE_DN: begin
            play_next = 1'b0;
            blue_next = lps_pkg::sat_dn(blue);
          end
          lps_pkg::CMD_RED_UP: begin
            play_next = 1'b0;
            red_next  = lps_pkg::sat_up(red);
          end
          lps_pkg::CMD_RED_DN: begin
            play_next = 1'b0;
            red_next  = lps_pkg::sat_dn(red);
          end
          lps_pkg::CMD_GREEN_UP: begin
            play_next  = 1'b0;
            green_next = lps_pkg::sat_up(green);
          end
          lps_pkg::CMD_GREEN_DN: begin
            play_next  = 1'b0;
            green_next = lps_pkg::sat_dn(green);
          end
          lps_pkg::CMD_PLAY: begin
            play_next    = !play;
            tone_on_next = 1'b0;
            tone_next    = '0;
            if (!play) begin
              step_next  = '0;
              accum_next = '0;
            end
          end
          lps_pkg::CMD_NEXT: begin
            tone_on_next = 1'b0;
            tone_next    = '0;
            red_next     = '0;
            blue_next    = '0;
            pattern_next = (pattern >= PAT_LAST) ? 3'd0 : pattern + 3'd1;
            step_next    = '0;
          end
          lps_pkg::CMD_PREV: begin
            tone_on_next = 1'b0;
            tone_next    = '0;
            red_next     = '0;
            blue_next    = '0;
            pattern_next = (pattern == 3'd0) ? PAT_LAST : pattern - 3'd1;
            step_next    = '0;
          end
          default: unknown = 1'b1;
        endcase
      end else if (play && (len != 5'd0)) begin
        // Tick while playing: accumulate, apply the step when it expires
        step_next  = step_eff;
        accum_next = sum;
        if (sum >= dur_full) begin
          accum_next = '0;
          red_next   = entry.red;
          green_next = entry.green;
          blue_next  = entry.blue;
          if (entry.lamp_one_act[lps_pkg::LAMP_APPLY_BIT]) begin
            lamp_one_next = entry.lamp_one_act[0];
          end
          if (entry.lamp_two_act[lps_pkg::LAMP_APPLY_BIT]) begin
            lamp_two_next = entry.lamp_two_act[0];
          end
          if (entry.tone_set) begin
            tone_on_next = (entry.tone_hz != 11'd0);
            tone_next    = entry.tone_hz;
          end
          step_next = step_inc;
        end
      end
    end
  end

  assign pattern_look = pattern_next;
  assign step_look    = step_next;

  // Result as seen after this transaction
  always_comb begin
    res_next.red_level       = red_next;
    res_next.green_level     = green_next;
    res_next.blue_level      = blue_next;
    res_next.lamp_one        = lamp_one_next;
    res_next.lamp_two        = lamp_two_next;
    res_next.tone_hz         = tone_on_next ? tone_next : 11'd0;
    res_next.tone_active     = tone_on_next;
    res_next.playing         = play_next;
    res_next.pattern_number  = pattern_next;
    res_next.step_number     = step_next;
    res_next.unknown_command = unknown;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red      <= '0;
      green    <= '0;
      blue     <= '0;
      lamp_one <= 1'b0;
      lamp_two <= 1'b0;
      play     <= 1'b0;
      tone_on  <= 1'b0;
      pattern  <= '0;
      step     <= '0;
      accum    <= '0;
      tone     <= '0;
    end else begin
      red      <= red_next;
      green    <= green_next;
      blue     <= blue_next;
      lamp_one <= lamp_one_next;
      lamp_two <= lamp_two_next;
      play     <= play_next;
      tone_on  <= tone_on_next;
      pattern  <= pattern_next;
      step     <= step_next;
      accum    <= accum_next;
      tone     <= tone_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_pattern_sequencer.sv =====
`default_nettype none

// Channel  Signals                               Carries
// -------  ------------------------------------  -------------------------------
// item     item_valid, item_ready, item          tick with speed, or command byte
// result   result_valid, result_ready, result    colour, lamp, tone and playback state
//
// One transaction per cycle sustained while result_ready is high; a taken item
// passes the pattern RAM read, then the state update into the output register.
// The RAM address for the next item is formed from the state that the item in
// the update stage is just producing, so back-to-back items see current state.
// After reset the step table is copied into the pattern RAM with item_ready low.
// A stalled result holds the update stage and the input.
module led_pattern_sequencer #(
  parameter int ROM_DEPTH     = lps_pkg::ROM_DEPTH_DEF,
  parameter int PATTERN_COUNT = lps_pkg::PATTERN_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire lps_pkg::item_t    item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output lps_pkg::result_t       result
);

  localparam int AW     = $clog2(ROM_DEPTH);
  localparam int STEP_W = $bits(lps_pkg::step_t);

  logic              fill_we;
  logic [AW-1:0]     fill_addr;
  logic [STEP_W-1:0] fill_data;
  logic              fill_done;

  logic              accept;
  logic              s1_valid;
  logic              s1_adv;
  lps_pkg::item_t    s1_item;
  logic              s1_oob;
  logic [STEP_W-1:0] rd_data;
  lps_pkg::step_t    entry;
  lps_pkg::result_t  res_next;

  logic [2:0]        pattern_look;
  logic [4:0]        step_look;
  logic [4:0]        look_len;
  logic [4:0]        look_step;
  logic [8:0]        look_idx;
  logic              look_oob;

  lps_loader #(
    .DEPTH (ROM_DEPTH)
  ) u_loader (
    .clk   (clk),
    .rst   (rst),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .done  (fill_done)
  );

  lps_ram #(
    .WIDTH (STEP_W),
    .DEPTH (ROM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (accept),
    .raddr (look_idx[AW-1:0]),
    .rdata (rd_data)
  );

  lps_core #(
    .PATTERN_COUNT (PATTERN_COUNT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .commit       (s1_adv),
    .item         (s1_item),
    .entry        (entry),
    .res_next     (res_next),
    .pattern_look (pattern_look),
    .step_look    (step_look)
  );

  // Handshake and stage control
  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = fill_done && (!s1_valid || s1_adv);
  assign accept     = item_valid && item_ready;

  // Table address of the step the next tick would use
  always_comb begin
    look_len  = lps_pkg::pat_len(pattern_look);
    look_step = (step_look >= look_len) ? 5'd0 : step_look;
    look_idx  = {1'b0, lps_pkg::pat_start(pattern_look)} + {4'b0, look_step};
    look_oob  = (look_idx >= 9'(ROM_DEPTH));
  end

  // Entries past the RAM read as black with no actions
  assign entry = s1_oob ? '0 : lps_pkg::step_t'(rd_data);

  // Update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_oob  <= look_oob;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= res_next;
    end
  end

  // Checks
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    accept |-> fill_done)
    else $error("transaction taken while pattern RAM is loading");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("update stage dropped a transaction");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("committed transaction produced no result");

  a_silent_tone: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.tone_active |-> result.tone_hz == 11'd0)
    else $error("tone frequency shown while buzzer is off");

  a_pattern_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> {1'b0, result.pattern_number} < 4'(PATTERN_COUNT))
    else $error("pattern index out of range");

endmodule

`default_nettype wire
